// ===== design/hld_pkg.sv =====
// Shared types, constants and the Q1.14 sine/cosine lookup for the line detector.
// Used by hld_front, hld_back, hld_emit and hough_line_detector; depends on nothing.
`default_nettype none

package hld_pkg;

  localparam logic [7:0] WHITE = 8'hFF;
  localparam int Q14_HALF = 8192;
  localparam int ARM_LEN = 1000;

  localparam int QSINE [91] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  typedef struct packed {
    logic       vote;
    logic       eof;
    logic [7:0] row;
    logic [7:0] col;
  } job_t;

  typedef struct packed {
    logic found;
    logic last;
    logic dropped;
  } ctrl_t;

  function automatic logic signed [15:0] sin_q14(input logic [8:0] deg);
    int d;
    int v;
    d = (int'(deg) >= 360) ? int'(deg) - 360 : int'(deg);
    if (d <= 90) begin
      v = QSINE[d];
    end else if (d <= 180) begin
      v = QSINE[180 - d];
    end else if (d <= 270) begin
      v = -QSINE[d - 180];
    end else begin
      v = -QSINE[360 - d];
    end
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] cos_q14(input logic [8:0] deg);
    logic [9:0] e;
    e = {1'b0, deg} + 10'd90;
    if (e >= 10'd360) begin
      e = e - 10'd360;
    end
    return sin_q14(e[8:0]);
  endfunction

endpackage

`default_nettype wire

// ===== design/hld_ram.sv =====
// Generic single-write, single-read RAM with registered read data (old data on collision).
// No dependencies.
`default_nettype none

module hld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/hld_front.sv =====
// Front end: accepts pixels, classifies them as voting or not, and queues jobs.
// Depends on hld_pkg.
`default_nettype none

module hld_front #(
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    pixel_value,
  input  wire logic [7:0]    pixel_row,
  input  wire logic [7:0]    pixel_col,
  input  wire logic          end_of_frame,
  output logic               job_valid,
  output hld_pkg::job_t      job,
  input  wire logic          job_pop
);

  hld_pkg::job_t q0, q1, nj;
  logic [1:0] cnt;
  logic do_push;

  assign full = (cnt == 2'd2);
  assign do_push = push && !full;
  assign job_valid = (cnt != 2'd0);
  assign job = q0;

  always_comb begin
    nj.vote = (pixel_value == hld_pkg::WHITE) && (32'(pixel_row) < MAX_ROWS)
              && (32'(pixel_col) < MAX_COLS);
    nj.eof = end_of_frame;
    nj.row = pixel_row;
    nj.col = pixel_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({do_push, job_pop})
        2'b10: cnt <= cnt + 2'd1;
        2'b01: cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({do_push, job_pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          q0 <= nj;
        end else begin
          q1 <= nj;
        end
      end
      2'b01: begin
        q0 <= q1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          q0 <= nj;
        end else begin
          q0 <= q1;
          q1 <= nj;
        end
      end
      default: begin
        q0 <= q0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/hld_emit.sv =====
// Result stage: computes line endpoints from theta and rho and holds the result register.
// Depends on hld_pkg.
`default_nettype none

module hld_emit #(
  parameter int TW = 8,
  parameter int RW = 9
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                ln_valid,
  output logic                     ln_ready,
  input  wire logic [TW-1:0]       ln_theta,
  input  wire logic [RW-1:0]       ln_rho,
  input  wire hld_pkg::ctrl_t      ln_ctrl,
  input  wire logic                pop,
  output logic                     empty,
  output logic                     line_found,
  output logic [7:0]               theta_index,
  output logic [8:0]               rho_index,
  output logic signed [11:0]       end1_x,
  output logic signed [11:0]       end1_y,
  output logic signed [11:0]       end2_x,
  output logic signed [11:0]       end2_y,
  output logic                     last_line,
  output logic                     lines_dropped
);

  function automatic logic [11:0] round_sat(input logic signed [31:0] q);
    logic [31:0] mag;
    logic [31:0] v;
    logic [11:0] res;
    mag = q[31] ? 32'(-q) : 32'(q);
    v = (mag + 32'(hld_pkg::Q14_HALF)) >> 14;
    if (q[31]) begin
      res = (v > 32'd2048) ? 12'h800 : 12'(~v + 32'd1);
    end else begin
      res = (v > 32'd2047) ? 12'h7FF : v[11:0];
    end
    return res;
  endfunction

  logic                   s1_v;
  logic [TW-1:0]          s1_theta;
  logic [RW-1:0]          s1_rho;
  hld_pkg::ctrl_t         s1_ctrl;
  logic signed [31:0]     s1_br, s1_ar, s1_ka, s1_kb;
  logic signed [15:0]     ca, sb;
  logic                   ov;
  logic                   out_adv;

  assign ca = hld_pkg::cos_q14(9'(ln_theta));
  assign sb = hld_pkg::sin_q14(9'(ln_theta));
  assign out_adv = !ov || pop;
  assign ln_ready = !s1_v || out_adv;
  assign empty = !ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (ln_ready) begin
        s1_v <= ln_valid;
      end
      if (out_adv) begin
        ov <= s1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ln_ready && ln_valid) begin
      s1_theta <= ln_theta;
      s1_rho <= ln_rho;
      s1_ctrl <= ln_ctrl;
      s1_br <= 32'(sb * $signed({1'b0, ln_rho}));
      s1_ar <= 32'(ca * $signed({1'b0, ln_rho}));
      s1_ka <= 32'(ca * 32'sd1000);
      s1_kb <= 32'(sb * 32'sd1000);
    end
    if (out_adv && s1_v) begin
      line_found <= s1_ctrl.found;
      last_line <= s1_ctrl.last;
      lines_dropped <= s1_ctrl.dropped;
      theta_index <= s1_ctrl.found ? 8'(s1_theta) : 8'd0;
      rho_index <= s1_ctrl.found ? 9'(s1_rho) : 9'd0;
      end1_x <= s1_ctrl.found ? round_sat(s1_br + s1_ka) : 12'd0;
      end1_y <= s1_ctrl.found ? round_sat(s1_ar - s1_kb) : 12'd0;
      end2_x <= s1_ctrl.found ? round_sat(s1_br - s1_ka) : 12'd0;
      end2_y <= s1_ctrl.found ? round_sat(s1_ar + s1_kb) : 12'd0;
    end
  end

endmodule

`default_nettype wire

// ===== design/hld_back.sv =====
// Back end: vote pipeline over theta bins, end-of-frame scan with clear, reset clear pass.
// Depends on hld_pkg and hld_ram.
`default_nettype none

module hld_back #(
  parameter int THETA_BINS  = 180,
  parameter int RHO_BINS    = 512,
  parameter int COUNT_WIDTH = 16,
  parameter int MAX_LINES   = 64,
  parameter int TW          = 8,
  parameter int RW          = 9
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  input  wire hld_pkg::job_t   job,
  output logic                 job_pop,
  input  wire logic [15:0]     vote_threshold,
  input  wire logic [7:0]      theta_bins_used,
  output logic                 ln_valid,
  input  wire logic            ln_ready,
  output logic [TW-1:0]        ln_theta,
  output logic [RW-1:0]        ln_rho,
  output hld_pkg::ctrl_t       ln_ctrl
);

  localparam int TOTAL = THETA_BINS * RHO_BINS;
  localparam int AW    = $clog2(TOTAL);
  localparam int AW1   = $clog2(TOTAL + 1);
  localparam int CNW   = $clog2(MAX_LINES + 1);
  localparam int CMPW  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_VOTE   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;

  logic [AW-1:0]          clr_addr;
  logic [TW-1:0]          vt;
  logic [AW-1:0]          vbase;
  logic [7:0]             row, col, nb_l, nb;
  logic                   eof_l;
  logic                   vote_last;

  logic                   s1_v;
  logic [AW-1:0]          s1_base;
  logic signed [24:0]     s1_p1, s1_p2;
  logic signed [15:0]     cos_v, sin_v;
  logic signed [25:0]     vsum;
  logic [25:0]            vmag;
  logic [11:0]            vrho;

  logic                   s2_v;
  logic [AW-1:0]          s2_addr;
  logic                   s3_v;
  logic [AW-1:0]          s3_addr;
  logic                   bp_v;
  logic [AW-1:0]          bp_addr;
  logic [COUNT_WIDTH-1:0] bp_data;
  logic [COUNT_WIDTH-1:0] cur, inc;

  logic [AW1-1:0]         sa;
  logic [TW-1:0]          st;
  logic [RW-1:0]          sr;
  logic                   ev_v;
  logic [AW-1:0]          ev_addr;
  logic [TW-1:0]          ev_t;
  logic [RW-1:0]          ev_r;
  logic                   pv;
  logic [TW-1:0]          p_t;
  logic [RW-1:0]          p_r;
  logic [CNW-1:0]         cnt;
  logic                   dropped;
  logic                   qual, at_max, need_out, stall, iss;

  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [COUNT_WIDTH-1:0] wdata, rdata;

  hld_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TOTAL)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign nb = (32'(theta_bins_used) < THETA_BINS) ? theta_bins_used : 8'(THETA_BINS);
  assign job_pop = (state == ST_IDLE) && job_valid;
  assign vote_last = (32'(vt) + 32'd1 >= 32'(nb_l));

  assign cos_v = hld_pkg::cos_q14(9'(vt));
  assign sin_v = hld_pkg::sin_q14(9'(vt));
  assign vsum = 26'(s1_p1) + 26'(s1_p2);
  assign vmag = vsum[25] ? 26'(-vsum) : 26'(vsum);
  assign vrho = 12'((vmag + 26'(hld_pkg::Q14_HALF)) >> 14);

  assign cur = (bp_v && bp_addr == s3_addr) ? bp_data : rdata;
  assign inc = (cur == '1) ? cur : cur + 1'b1;

  assign qual = ev_v && (32'(ev_t) < 32'(nb_l))
                && (CMPW'(rdata) > CMPW'(vote_threshold));
  assign at_max = (32'(cnt) == MAX_LINES);
  assign need_out = qual && !at_max && pv;
  assign stall = need_out && !ln_ready;
  assign iss = (32'(sa) < TOTAL) && !stall;

  always_comb begin
    we = 1'b0;
    waddr = s3_addr;
    wdata = inc;
    re = s2_v;
    raddr = s2_addr;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_SCAN: begin
        we = ev_v && !stall;
        waddr = ev_addr;
        wdata = '0;
        re = iss;
        raddr = sa[AW-1:0];
      end
      default: begin
        we = s3_v;
      end
    endcase
  end

  always_comb begin
    ln_valid = 1'b0;
    ln_theta = p_t;
    ln_rho = p_r;
    ln_ctrl.found = 1'b1;
    ln_ctrl.last = 1'b0;
    ln_ctrl.dropped = 1'b0;
    case (state)
      ST_SCAN: begin
        ln_valid = need_out;
      end
      ST_FINISH: begin
        ln_valid = 1'b1;
        ln_theta = pv ? p_t : '0;
        ln_rho = pv ? p_r : '0;
        ln_ctrl.found = pv;
        ln_ctrl.last = 1'b1;
        ln_ctrl.dropped = dropped && pv;
      end
      default: begin
        ln_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      bp_v <= 1'b0;
      ev_v <= 1'b0;
      pv <= 1'b0;
      cnt <= '0;
      dropped <= 1'b0;
    end else begin
      s1_v <= (state == ST_VOTE);
      s2_v <= s1_v && (32'(vrho) < RHO_BINS);
      s3_v <= s2_v;
      bp_v <= s3_v;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (32'(clr_addr) == TOTAL - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (job_valid) begin
            if (job.vote && nb != 8'd0) begin
              state <= ST_VOTE;
            end else if (job.eof) begin
              state <= ST_DRAIN;
            end
          end
        end
        ST_VOTE: begin
          if (vote_last) begin
            state <= eof_l ? ST_DRAIN : ST_IDLE;
          end
        end
        ST_DRAIN: begin
          ev_v <= 1'b0;
          if (!s1_v && !s2_v && !s3_v) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stall) begin
            ev_v <= 1'b0;
          end else begin
            ev_v <= iss;
            if (qual) begin
              if (at_max) begin
                dropped <= 1'b1;
              end else begin
                pv <= 1'b1;
                cnt <= cnt + 1'b1;
              end
            end
          end
          if ((32'(sa) == TOTAL) && !ev_v) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (ln_ready) begin
            pv <= 1'b0;
            cnt <= '0;
            dropped <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && job_valid) begin
      row <= job.row;
      col <= job.col;
      eof_l <= job.eof;
      nb_l <= nb;
      vt <= '0;
      vbase <= '0;
    end else if (state == ST_VOTE) begin
      vt <= vt + 1'b1;
      vbase <= vbase + AW'(RHO_BINS);
    end
    s1_base <= vbase;
    s1_p1 <= 25'($signed({1'b0, row}) * cos_v);
    s1_p2 <= 25'($signed({1'b0, col}) * sin_v);
    s2_addr <= s1_base + AW'(vrho);
    s3_addr <= s2_addr;
    bp_addr <= s3_addr;
    bp_data <= inc;
    if (state == ST_DRAIN) begin
      sa <= '0;
      st <= '0;
      sr <= '0;
    end else if (state == ST_SCAN) begin
      if (stall) begin
        sa <= AW1'(ev_addr);
        st <= ev_t;
        sr <= ev_r;
      end else if (iss) begin
        ev_addr <= sa[AW-1:0];
        ev_t <= st;
        ev_r <= sr;
        sa <= sa + 1'b1;
        if (32'(sr) == RHO_BINS - 1) begin
          sr <= '0;
          st <= st + 1'b1;
        end else begin
          sr <= sr + 1'b1;
        end
      end
      if (!stall && qual && !at_max) begin
        p_t <= ev_t;
        p_r <= ev_r;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/hough_line_detector.sv =====
// Top level of the Hough line detector: configuration registers, front end, back end, result stage.
// Depends on hld_pkg, hld_front, hld_back, hld_emit (and hld_ram through hld_back).
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------------------------
//   pixel in | push / full        | pixel_value, pixel_row, pixel_col, end_of_frame
//   line out | pop / empty        | line_found, theta_index, rho_index, end1_x..end2_y, flags
//   config   | psel/penable/pwrite| paddr 0: vote_threshold, paddr 4: theta_bins_used
//
// A white pixel is voted over each used theta bin in turn, through the single store.
// End of frame scans and clears all THETA_BINS*RHO_BINS store entries, one per cycle unless a result stalls the scan.
// After reset a clear pass zeroes all THETA_BINS*RHO_BINS store entries before pixels are voted.
// Pixels queue two deep ahead of the vote engine; a stalled result pauses the scan only.
`default_nettype none

module hough_line_detector #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLS    = 256,
  parameter int THETA_BINS  = 180,
  parameter int RHO_BINS    = 512,
  parameter int COUNT_WIDTH = 16,
  parameter int MAX_LINES   = 64
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [7:0]         pixel_value,
  input  wire logic [7:0]         pixel_row,
  input  wire logic [7:0]         pixel_col,
  input  wire logic               end_of_frame,
  input  wire logic               pop,
  output logic                    empty,
  output logic                    line_found,
  output logic [7:0]              theta_index,
  output logic [8:0]              rho_index,
  output logic signed [11:0]      end1_x,
  output logic signed [11:0]      end1_y,
  output logic signed [11:0]      end2_x,
  output logic signed [11:0]      end2_y,
  output logic                    last_line,
  output logic                    lines_dropped,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int TW = (THETA_BINS > 1) ? $clog2(THETA_BINS) : 1;
  localparam int RW = $clog2(RHO_BINS);

  logic [15:0]     vote_threshold;
  logic [7:0]      theta_bins_used;
  logic            job_valid, job_pop;
  hld_pkg::job_t   job;
  logic            ln_valid, ln_ready;
  logic [TW-1:0]   ln_theta;
  logic [RW-1:0]   ln_rho;
  hld_pkg::ctrl_t  ln_ctrl;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'd0, theta_bins_used} : {16'd0, vote_threshold};

  always_ff @(posedge clk) begin
    if (rst) begin
      vote_threshold <= 16'd100;
      theta_bins_used <= 8'd180;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        theta_bins_used <= pwdata[7:0];
      end else begin
        vote_threshold <= pwdata[15:0];
      end
    end
  end

  hld_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .pixel_value  (pixel_value),
    .pixel_row    (pixel_row),
    .pixel_col    (pixel_col),
    .end_of_frame (end_of_frame),
    .job_valid    (job_valid),
    .job          (job),
    .job_pop      (job_pop)
  );

  hld_back #(
    .THETA_BINS  (THETA_BINS),
    .RHO_BINS    (RHO_BINS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .MAX_LINES   (MAX_LINES),
    .TW          (TW),
    .RW          (RW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .job_valid       (job_valid),
    .job             (job),
    .job_pop         (job_pop),
    .vote_threshold  (vote_threshold),
    .theta_bins_used (theta_bins_used),
    .ln_valid        (ln_valid),
    .ln_ready        (ln_ready),
    .ln_theta        (ln_theta),
    .ln_rho          (ln_rho),
    .ln_ctrl         (ln_ctrl)
  );

  hld_emit #(.TW(TW), .RW(RW)) u_emit (
    .clk           (clk),
    .rst           (rst),
    .ln_valid      (ln_valid),
    .ln_ready      (ln_ready),
    .ln_theta      (ln_theta),
    .ln_rho        (ln_rho),
    .ln_ctrl       (ln_ctrl),
    .pop           (pop),
    .empty         (empty),
    .line_found    (line_found),
    .theta_index   (theta_index),
    .rho_index     (rho_index),
    .end1_x        (end1_x),
    .end1_y        (end1_y),
    .end2_x        (end2_x),
    .end2_y        (end2_y),
    .last_line     (last_line),
    .lines_dropped (lines_dropped)
  );

endmodule

`default_nettype wire
